/* hw/rtl/scc_pkg.sv */
// Shared types and widths for the sphere versus capsule collision pipeline.
`default_nettype none

package scc_pkg;

	localparam int CoordW  = 24;
	localparam int RadiusW = 23;

	typedef struct packed {
		logic signed [CoordW-1:0]  sphere_x;
		logic signed [CoordW-1:0]  sphere_y;
		logic signed [CoordW-1:0]  sphere_z;
		logic        [RadiusW-1:0] sphere_radius;
		logic signed [CoordW-1:0]  axis_start_x;
		logic signed [CoordW-1:0]  axis_start_y;
		logic signed [CoordW-1:0]  axis_start_z;
		logic signed [CoordW-1:0]  axis_end_x;
		logic signed [CoordW-1:0]  axis_end_y;
		logic signed [CoordW-1:0]  axis_end_z;
		logic        [RadiusW-1:0] capsule_radius;
	} query_t;

	typedef struct packed {
		logic                     hit;
		logic signed [CoordW-1:0] contact_x;
		logic signed [CoordW-1:0] contact_y;
		logic signed [CoordW-1:0] contact_z;
	} result_t;

	// Geometry carried alongside the arithmetic down the pipeline.
	typedef struct packed {
		logic [2:0][CoordW-1:0] p;
		logic [2:0][CoordW-1:0] a;
		logic [2:0][CoordW-1:0] b;
		logic [RadiusW-1:0]     rc;
		logic [CoordW-1:0]      rsum;
	} geo_t;

endpackage

`default_nettype wire

/* hw/rtl/scc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
`default_nettype none

module scc_div_pipe #(
	parameter int Lanes = 3,
	parameter int DenW  = 52,
	parameter int QuoW  = 24,
	parameter int SideW = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [Lanes-1:0][DenW+QuoW-1:0]     num,
	input  logic [DenW-1:0]                     den,
	input  logic [SideW-1:0]                    in_side,
	output logic                                out_valid,
	output logic [Lanes-1:0][QuoW-1:0]          quo,
	output logic [SideW-1:0]                    out_side
);

	localparam int RemW = DenW + QuoW;

	logic                          vld_s  [QuoW+1];
	logic [Lanes-1:0][RemW-1:0]    rem_s  [QuoW+1];
	logic [DenW-1:0]               den_s  [QuoW+1];
	logic [Lanes-1:0][QuoW-1:0]    quo_s  [QuoW+1];
	logic [SideW-1:0]              side_s [QuoW+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < QuoW; j++) begin : g_step
		localparam int Sh = QuoW - 1 - j;
		logic [RemW-1:0]            dsh;
		logic [Lanes-1:0][RemW-1:0] rem_n;
		logic [Lanes-1:0][QuoW-1:0] quo_n;

		always_comb begin
			dsh   = RemW'(den_s[j]) << Sh;
			rem_n = rem_s[j];
			quo_n = quo_s[j];
			for (int l = 0; l < Lanes; l++) begin
				if (rem_s[j][l] >= dsh) begin
					rem_n[l]     = rem_s[j][l] - dsh;
					quo_n[l][Sh] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= rem_n;
			den_s[j+1]  <= den_s[j];
			quo_s[j+1]  <= quo_n;
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_valid = vld_s[QuoW];
	assign quo       = quo_s[QuoW];
	assign out_side  = side_s[QuoW];

endmodule

`default_nettype wire

/* hw/rtl/sphere_capsule_collision.sv */
// Sphere versus capsule overlap test with pseudo contact point, fully pipelined.
// Throughput: one item per cycle; busy is always low.
// The pipeline is two bit-per-stage dividers (24 and 25 stages) plus 9 arithmetic stages.
// Reset clears the valid bits only; the receiver cannot stall, so done is a one-cycle strobe.
`default_nettype none

module sphere_capsule_collision (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  scc_pkg::query_t   query,
	output logic              done,
	output scc_pkg::result_t  result
);

	typedef struct packed {
		logic          hit;
		logic          at_start;
		logic          at_end;
		logic [2:0]    sneg;
		scc_pkg::geo_t geo;
	} side1_t;

	typedef struct packed {
		logic             hit;
		logic             rz;
		logic [2:0]       dneg;
		logic [2:0][24:0] c;
	} side2_t;

	logic take;
	assign busy = 1'b0;
	assign take = start & ~busy;

	logic signed [23:0] p_in [3];
	logic signed [23:0] a_in [3];
	logic signed [23:0] b_in [3];

	always_comb begin
		p_in[0] = query.sphere_x;
		p_in[1] = query.sphere_y;
		p_in[2] = query.sphere_z;
		a_in[0] = query.axis_start_x;
		a_in[1] = query.axis_start_y;
		a_in[2] = query.axis_start_z;
		b_in[0] = query.axis_end_x;
		b_in[1] = query.axis_end_y;
		b_in[2] = query.axis_end_z;
	end

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_d1, v_s6, v_s7, v_s8, v_d2, done_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			done_s9 <= 1'b0;
		end else begin
			v_s1    <= take;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_d1;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			done_s9 <= v_d2;
		end
	end

	// Stage 1: differences
	scc_pkg::geo_t      geo_s1;
	logic signed [24:0] s_s1  [3];
	logic signed [24:0] sp_s1 [3];
	logic signed [24:0] ep_s1 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			geo_s1.p[k] <= p_in[k];
			geo_s1.a[k] <= a_in[k];
			geo_s1.b[k] <= b_in[k];
			s_s1[k]     <= 25'(b_in[k]) - 25'(a_in[k]);
			sp_s1[k]    <= 25'(p_in[k]) - 25'(a_in[k]);
			ep_s1[k]    <= 25'(b_in[k]) - 25'(p_in[k]);
		end
		geo_s1.rc   <= query.capsule_radius;
		geo_s1.rsum <= 24'(query.sphere_radius) + 24'(query.capsule_radius);
	end

	// Stage 2: products
	scc_pkg::geo_t      geo_s2;
	logic signed [24:0] s_s2    [3];
	logic signed [49:0] ss_p_s2 [3];
	logic signed [49:0] d1_p_s2 [3];
	logic signed [49:0] d2_p_s2 [3];
	logic signed [49:0] da_p_s2 [3];
	logic signed [49:0] db_p_s2 [3];
	logic signed [49:0] xa_p_s2 [3];
	logic signed [49:0] xb_p_s2 [3];
	logic [47:0]        rsq_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ss_p_s2[k] <= s_s1[k] * s_s1[k];
			d1_p_s2[k] <= s_s1[k] * sp_s1[k];
			d2_p_s2[k] <= s_s1[k] * ep_s1[k];
			da_p_s2[k] <= sp_s1[k] * sp_s1[k];
			db_p_s2[k] <= ep_s1[k] * ep_s1[k];
		end
		xa_p_s2[0] <= s_s1[1] * ep_s1[2];
		xb_p_s2[0] <= s_s1[2] * ep_s1[1];
		xa_p_s2[1] <= s_s1[2] * ep_s1[0];
		xb_p_s2[1] <= s_s1[0] * ep_s1[2];
		xa_p_s2[2] <= s_s1[0] * ep_s1[1];
		xb_p_s2[2] <= s_s1[1] * ep_s1[0];
		rsq_s2     <= 48'(geo_s1.rsum) * 48'(geo_s1.rsum);
		s_s2       <= s_s1;
		geo_s2     <= geo_s1;
	end

	// Stage 3: dot products, squared lengths, cross product
	scc_pkg::geo_t      geo_s3;
	logic signed [24:0] s_s3 [3];
	logic signed [51:0] d1_s3, d2_s3;
	logic [51:0]        ss_s3;
	logic [49:0]        da_s3, db_s3;
	logic signed [50:0] x_s3 [3];
	logic [47:0]        rsq_s3;

	always_ff @(posedge clk) begin
		ss_s3  <= 52'(ss_p_s2[0]) + 52'(ss_p_s2[1]) + 52'(ss_p_s2[2]);
		d1_s3  <= 52'(d1_p_s2[0]) + 52'(d1_p_s2[1]) + 52'(d1_p_s2[2]);
		d2_s3  <= 52'(d2_p_s2[0]) + 52'(d2_p_s2[1]) + 52'(d2_p_s2[2]);
		da_s3  <= 50'(52'(da_p_s2[0]) + 52'(da_p_s2[1]) + 52'(da_p_s2[2]));
		db_s3  <= 50'(52'(db_p_s2[0]) + 52'(db_p_s2[1]) + 52'(db_p_s2[2]));
		for (int k = 0; k < 3; k++) begin
			x_s3[k] <= 51'(xa_p_s2[k]) - 51'(xb_p_s2[k]);
		end
		rsq_s3 <= rsq_s2;
		s_s3   <= s_s2;
		geo_s3 <= geo_s2;
	end

	// Stage 4: region choice, end-point test, split partial products
	logic        start_c, end_c;
	logic [49:0] dist_c;
	logic [50:0] xm   [3];
	logic [23:0] smag [3];

	always_comb begin
		// tolerance is below one step: not positive means <= 0
		start_c = (d1_s3 <= 52'sd0);
		end_c   = ~start_c & (d2_s3 <= 52'sd0);
		dist_c  = start_c ? da_s3 : db_s3;
		for (int k = 0; k < 3; k++) begin
			xm[k]   = x_s3[k][50] ? 51'(-x_s3[k]) : 51'(x_s3[k]);
			smag[k] = s_s3[k][24] ? 24'(-s_s3[k]) : 24'(s_s3[k]);
		end
	end

	scc_pkg::geo_t geo_s4;
	logic          at_start_s4, at_end_s4, hit_e_s4;
	logic [2:0]    sneg_s4;
	logic [49:0]   hh_s4 [3];
	logic [50:0]   hl_s4 [3];
	logic [51:0]   ll_s4 [3];
	logic [49:0]   rq_s4 [4];
	logic [49:0]   nh_s4 [3];
	logic [49:0]   nl_s4 [3];
	logic [51:0]   ss_s4;

	always_ff @(posedge clk) begin
		at_start_s4 <= start_c;
		at_end_s4   <= end_c;
		hit_e_s4    <= (dist_c <= 50'(rsq_s3));
		for (int k = 0; k < 3; k++) begin
			hh_s4[k]   <= 50'(xm[k][50:26]) * 50'(xm[k][50:26]);
			hl_s4[k]   <= 51'(xm[k][50:26]) * 51'(xm[k][25:0]);
			ll_s4[k]   <= 52'(xm[k][25:0]) * 52'(xm[k][25:0]);
			nh_s4[k]   <= 50'(smag[k]) * 50'(d1_s3[51:26]);
			nl_s4[k]   <= 50'(smag[k]) * 50'(d1_s3[25:0]);
			sneg_s4[k] <= s_s3[k][24];
		end
		rq_s4[0] <= 50'(rsq_s3[47:24]) * 50'(ss_s3[51:26]);
		rq_s4[1] <= 50'(rsq_s3[47:24]) * 50'(ss_s3[25:0]);
		rq_s4[2] <= 50'(rsq_s3[23:0]) * 50'(ss_s3[51:26]);
		rq_s4[3] <= 50'(rsq_s3[23:0]) * 50'(ss_s3[25:0]);
		ss_s4    <= ss_s3;
		geo_s4   <= geo_s3;
	end

	// Stage 5: assemble wide sums and divider operands
	logic [103:0]       lhs_n;
	logic [2:0][75:0]   num_n;

	always_comb begin
		lhs_n = '0;
		for (int k = 0; k < 3; k++) begin
			lhs_n = lhs_n + (104'(hh_s4[k]) << 52) + (104'(hl_s4[k]) << 27)
				+ 104'(ll_s4[k]);
			num_n[k] = (((76'(nh_s4[k]) << 26) + 76'(nl_s4[k])) << 1) + 76'(ss_s4);
		end
	end

	scc_pkg::geo_t    geo_s5;
	logic             at_start_s5, at_end_s5, hit_e_s5;
	logic [2:0]       sneg_s5;
	logic [103:0]     lhs_s5, rhs_s5;
	logic [2:0][75:0] num_s5;
	logic [51:0]      den_s5;

	always_ff @(posedge clk) begin
		lhs_s5      <= lhs_n;
		rhs_s5      <= (104'(rq_s4[0]) << 50) + (104'(rq_s4[1]) << 24)
			+ (104'(rq_s4[2]) << 26) + 104'(rq_s4[3]);
		num_s5      <= num_n;
		den_s5      <= {ss_s4[50:0], 1'b0};
		at_start_s5 <= at_start_s4;
		at_end_s5   <= at_end_s4;
		hit_e_s5    <= hit_e_s4;
		sneg_s5     <= sneg_s4;
		geo_s5      <= geo_s4;
	end

	side1_t side1_in, side1_out;

	always_comb begin
		side1_in.hit      = (at_start_s5 | at_end_s5) ? hit_e_s5 : (lhs_s5 <= rhs_s5);
		side1_in.at_start = at_start_s5;
		side1_in.at_end   = at_end_s5;
		side1_in.sneg     = sneg_s5;
		side1_in.geo      = geo_s5;
	end

	logic [2:0][23:0] q_d1;

	// interior parameter: round(s_k * d1 / |S|^2)
	scc_div_pipe #(
		.Lanes (3),
		.DenW  (52),
		.QuoW  (24),
		.SideW ($bits(side1_t))
	) u_div_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.num       (num_s5),
		.den       (den_s5),
		.in_side   (side1_in),
		.out_valid (v_d1),
		.quo       (q_d1),
		.out_side  (side1_out)
	);

	// Stage 6: closest axis point
	logic signed [24:0] qa   [3];
	logic signed [24:0] c_n  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qa[k] = signed'({1'b0, q_d1[k]});
			if (side1_out.sneg[k]) begin
				qa[k] = -qa[k];
			end
			priority if (side1_out.at_start) begin
				c_n[k] = 25'(signed'(side1_out.geo.a[k]));
			end else if (side1_out.at_end) begin
				c_n[k] = 25'(signed'(side1_out.geo.b[k]));
			end else begin
				c_n[k] = 25'(signed'(side1_out.geo.a[k])) + qa[k];
			end
		end
	end

	scc_pkg::geo_t      geo_s6;
	logic               hit_s6;
	logic signed [24:0] c_s6 [3];

	always_ff @(posedge clk) begin
		c_s6   <= c_n;
		hit_s6 <= side1_out.hit;
		geo_s6 <= side1_out.geo;
	end

	// Stage 7: span from closest point to center, as sign and magnitude
	logic signed [25:0] pe [3];
	logic signed [25:0] ce [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pe[k] = 26'(signed'(geo_s6.p[k]));
			ce[k] = 26'(c_s6[k]);
		end
	end

	logic               hit_s7;
	logic [2:0]         dneg_s7;
	logic [24:0]        dm_s7 [3];
	logic signed [24:0] c_s7  [3];
	logic [22:0]        rc_s7;
	logic [23:0]        rsum_s7;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dneg_s7[k] <= (pe[k] < ce[k]);
			dm_s7[k]   <= (pe[k] < ce[k]) ? 25'(ce[k] - pe[k]) : 25'(pe[k] - ce[k]);
		end
		c_s7    <= c_s6;
		hit_s7  <= hit_s6;
		rc_s7   <= geo_s6.rc;
		rsum_s7 <= geo_s6.rsum;
	end

	// Stage 8: scale span by capsule radius
	logic               hit_s8;
	logic [2:0]         dneg_s8;
	logic [47:0]        m2_s8 [3];
	logic signed [24:0] c_s8  [3];
	logic [23:0]        rsum_s8;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			m2_s8[k] <= 48'(dm_s7[k]) * 48'(rc_s7);
		end
		dneg_s8 <= dneg_s7;
		c_s8    <= c_s7;
		hit_s8  <= hit_s7;
		rsum_s8 <= rsum_s7;
	end

	logic [2:0][49:0] num2;
	side2_t           side2_in, side2_out;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num2[k]        = (50'(m2_s8[k]) << 1) + 50'(rsum_s8);
			side2_in.c[k]  = c_s8[k];
		end
		side2_in.hit  = hit_s8;
		side2_in.rz   = (rsum_s8 == '0);
		side2_in.dneg = dneg_s8;
	end

	logic [2:0][24:0] q_d2;

	// contact offset: round(span * rc / (rs + rc))
	scc_div_pipe #(
		.Lanes (3),
		.DenW  (25),
		.QuoW  (25),
		.SideW ($bits(side2_t))
	) u_div_contact (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.num       (num2),
		.den       ({rsum_s8, 1'b0}),
		.in_side   (side2_in),
		.out_valid (v_d2),
		.quo       (q_d2),
		.out_side  (side2_out)
	);

	// Stage 9: contact point, zero on a miss
	logic signed [25:0] qc  [3];
	logic signed [25:0] sum [3];
	logic [23:0]        cv  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qc[k] = signed'({1'b0, q_d2[k]});
			if (side2_out.dneg[k]) begin
				qc[k] = -qc[k];
			end
			sum[k] = 26'(signed'(side2_out.c[k])) + qc[k];
			priority if (!side2_out.hit) begin
				cv[k] = '0;
			end else if (side2_out.rz) begin
				cv[k] = side2_out.c[k][23:0];
			end else begin
				cv[k] = sum[k][23:0];
			end
		end
	end

	scc_pkg::result_t res_s9;

	always_ff @(posedge clk) begin
		res_s9.hit       <= side2_out.hit;
		res_s9.contact_x <= cv[0];
		res_s9.contact_y <= cv[1];
		res_s9.contact_z <= cv[2];
	end

	assign done   = done_s9;
	assign result = res_s9;

`ifndef SYNTHESIS
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##58 done)
		else $error("accepted item did not reach done after 58 cycles");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 58))
		else $error("done without an item accepted 58 cycles earlier");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |->
		(result.contact_x == '0 && result.contact_y == '0 && result.contact_z == '0))
		else $error("contact point not zero on a miss");
`endif

endmodule

`default_nettype wire

/* test/tb_sphere_capsule_collision.sv */
// Self-checking testbench for the sphere versus capsule collision pipeline.
`timescale 1ns / 1ps

module tb_sphere_capsule_collision;

	localparam int Latency   = 58;
	localparam int NumRandom = 450;
	localparam longint CycleLimit = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	scc_pkg::query_t query = '0;
	scc_pkg::result_t result;

	scc_pkg::result_t hit_queue[$];
	int mismatches = 0;
	int checked = 0;
	int hits_seen = 0;
	int sent = 0;
	longint cycle = 0;
	int idle_pct = 0;

	typedef struct {
		scc_pkg::query_t  q;
		bit               known;
		scc_pkg::result_t r;
	} row_t;
	row_t rows[$];

	sphere_capsule_collision DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.query(query), .done(done), .result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// round(a * b / den), ties away from zero, in wide arithmetic
	function automatic longint round_scale(longint a, longint b, longint den);
		logic [127:0] num;
		logic [127:0] q;
		longint m;
		m = a < 0 ? -a : a;
		num = 128'(m) * 128'(b) * 2 + 128'(den);
		q = num / (128'(den) * 2);
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic scc_pkg::result_t collide(scc_pkg::query_t q);
		longint p[3], a[3], b[3], s[3], sp[3], ep[3], c[3], x[3];
		longint rs, rc, rsum, rsq, ss, d1, d2, dsq, v;
		logic [127:0] lhs;
		bit h;
		scc_pkg::result_t r;
		p = '{q.sphere_x, q.sphere_y, q.sphere_z};
		a = '{q.axis_start_x, q.axis_start_y, q.axis_start_z};
		b = '{q.axis_end_x, q.axis_end_y, q.axis_end_z};
		rs = q.sphere_radius;
		rc = q.capsule_radius;
		rsum = rs + rc;
		rsq = rsum * rsum;
		ss = 0; d1 = 0; d2 = 0;
		for (int k = 0; k < 3; k++) begin
			s[k] = b[k] - a[k];
			sp[k] = p[k] - a[k];
			ep[k] = b[k] - p[k];
			ss += s[k] * s[k];
			d1 += s[k] * sp[k];
			d2 += s[k] * ep[k];
		end
		if (d1 <= 0 || d2 <= 0) begin
			dsq = 0;
			for (int k = 0; k < 3; k++) begin
				v = d1 <= 0 ? sp[k] : ep[k];
				dsq += v * v;
				c[k] = d1 <= 0 ? a[k] : b[k];
			end
			h = dsq <= rsq;
		end else begin
			x[0] = s[1] * ep[2] - s[2] * ep[1];
			x[1] = s[2] * ep[0] - s[0] * ep[2];
			x[2] = s[0] * ep[1] - s[1] * ep[0];
			lhs = '0;
			for (int k = 0; k < 3; k++)
				lhs += 128'(x[k] < 0 ? -x[k] : x[k]) * 128'(x[k] < 0 ? -x[k] : x[k]);
			h = lhs <= 128'(rsq) * 128'(ss);
			for (int k = 0; k < 3; k++)
				c[k] = a[k] + round_scale(s[k], d1, ss);
		end
		r = '0;
		r.hit = h;
		if (h) begin
			for (int k = 0; k < 3; k++) begin
				v = c[k];
				if (rsum != 0)
					v += round_scale(p[k] - c[k], rc, rsum);
				c[k] = v;
			end
			r.contact_x = c[0][23:0];
			r.contact_y = c[1][23:0];
			r.contact_z = c[2][23:0];
		end
		return r;
	endfunction

	function automatic logic [23:0] rand_coord(int span);
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($signed(span) - $signed($urandom_range(0, 2 * span)));
			2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return 24'($signed($urandom_range(0, 512)) - 256);
		endcase
	endfunction

	function automatic scc_pkg::query_t rand_query();
		scc_pkg::query_t q;
		int span;
		span = $urandom_range(0, 1) ? 4096 : 1 << $urandom_range(8, 22);
		q.sphere_x = rand_coord(span);
		q.sphere_y = rand_coord(span);
		q.sphere_z = rand_coord(span);
		q.axis_start_x = rand_coord(span);
		q.axis_start_y = rand_coord(span);
		q.axis_start_z = rand_coord(span);
		if ($urandom_range(0, 9) == 0) begin
			q.axis_end_x = q.axis_start_x;
			q.axis_end_y = q.axis_start_y;
			q.axis_end_z = q.axis_start_z;
		end else begin
			q.axis_end_x = rand_coord(span);
			q.axis_end_y = rand_coord(span);
			q.axis_end_z = rand_coord(span);
		end
		// mostly radii on the scale of the geometry so hits and misses mix
		case ($urandom_range(0, 4))
			0: begin q.sphere_radius = 23'($urandom); q.capsule_radius = 23'($urandom); end
			1: begin q.sphere_radius = '0; q.capsule_radius = '0; end
			default: begin
				q.sphere_radius = 23'($urandom_range(0, 2 * span));
				q.capsule_radius = 23'($urandom_range(0, 2 * span));
			end
		endcase
		return q;
	endfunction

	function automatic scc_pkg::query_t make_q(int px, int py, int pz, int rs,
			int ax, int ay, int az, int bx, int by, int bz, int rc);
		scc_pkg::query_t q;
		q.sphere_x = 24'(px); q.sphere_y = 24'(py); q.sphere_z = 24'(pz);
		q.sphere_radius = 23'(rs);
		q.axis_start_x = 24'(ax); q.axis_start_y = 24'(ay); q.axis_start_z = 24'(az);
		q.axis_end_x = 24'(bx); q.axis_end_y = 24'(by); q.axis_end_z = 24'(bz);
		q.capsule_radius = 23'(rc);
		return q;
	endfunction

	task automatic add_row(scc_pkg::query_t q, bit known, scc_pkg::result_t r);
		row_t w;
		w.q = q; w.known = known; w.r = r;
		rows.push_back(w);
	endtask

	task automatic send(scc_pkg::query_t q, scc_pkg::result_t exp);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		query <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		hit_queue.push_back(exp);
		sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		scc_pkg::result_t exp;
		cycle++;
		if (arst_n && done) begin
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", result);
			end else begin
				exp = hit_queue.pop_front();
				checked++;
				if (result.hit) hits_seen++;
				if (result.hit !== exp.hit || result.contact_x !== exp.contact_x ||
						result.contact_y !== exp.contact_y ||
						result.contact_z !== exp.contact_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp, result);
				end
			end
		end
		if (cycle > CycleLimit) begin
			$display("tb_sphere_capsule_collision: FAIL");
			$finish;
		end
	end

	initial begin
		scc_pkg::result_t r0;
		int phase_pct[4];
		phase_pct = '{0, 77, 0, 27};
		r0 = '0;
		// miss: zero contact
		add_row(make_q(25600, 0, 0, 256, 0, 0, 0, 0, 0, 0, 256), 1, r0);
		// sphere centered on capsule start, zero radii: hit at that point
		r0.hit = 1'b1; r0.contact_x = 24'(512); r0.contact_y = 24'(-512); r0.contact_z = '0;
		add_row(make_q(512, -512, 0, 0, 512, -512, 0, 512, -512, 0, 0), 1, r0);
		add_row(make_q(512, -512, 0, 0, 512, -512, 0, 4096, 0, 0, 0), 1, r0);
		// beyond end, interior, touching, zero-length axis, extremes
		add_row(make_q(5000, 0, 0, 100, 0, 0, 0, 4096, 0, 0, 200), 0, r0);
		add_row(make_q(2048, 300, 0, 100, 0, 0, 0, 4096, 0, 0, 200), 0, r0);
		add_row(make_q(2048, 300, 0, 100, 0, 0, 0, 4096, 0, 0, 199), 0, r0);
		add_row(make_q(2048, 300, 0, 100, 0, 0, 0, 4096, 0, 0, 201), 0, r0);
		add_row(make_q(-300, 400, 0, 200, 0, 0, 0, 0, 0, 0, 300), 0, r0);
		add_row(make_q(-300, 400, 0, 200, 0, 0, 0, 0, 0, 0, 299), 0, r0);
		add_row(make_q(100, 200, 300, 0, 0, 0, 0, 1000, 2000, 3000, 0), 0, r0);
		add_row(make_q(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
			-8388608, 8388607, 8388607, 8388607, 8388607), 0, r0);
		add_row(make_q(-8388608, 8388607, -8388608, 8388607, 8388607, -8388608,
			8388607, -8388608, 8388607, -8388608, 8388607), 0, r0);
		add_row(make_q(-8388608, -8388608, -8388608, 0, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607, 0), 0, r0);
		add_row(make_q(0, 0, 0, 8388607, 8388607, -8388608, 0, -8388608, 8388607,
			0, 0), 0, r0);
		add_row(make_q(777, -333, 123, 55, -1000, 17, 9, 3000, -20, 11, 8388607), 0, r0);
		add_row(make_q(777, -333, 123, 8388607, -1000, 17, 9, 3000, -20, 11, 0), 0, r0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send(rows[i].q, rows[i].known ? rows[i].r : collide(rows[i].q));
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_pct[ph];
			for (int i = 0; i < NumRandom / 4; i++) begin
				scc_pkg::query_t q;
				q = rand_query();
				send(q, collide(q));
			end
			// hold off until the pipeline drains
			start <= 1'b0;
			while (hit_queue.size() != 0) @(negedge clk);
		end
		start <= 1'b0;
		repeat (Latency + 10) @(negedge clk);
		$display("Sent %0d queries over four idling phases; %0d results checked, %0d hits.",
			sent, checked, hits_seen);
		if (mismatches == 0 && hit_queue.size() == 0)
			$display("tb_sphere_capsule_collision: PASS");
		else
			$display("tb_sphere_capsule_collision: FAIL");
		$finish;
	end

endmodule
